### design/fcr_pkg.sv
// Package: payload types and field widths for the Fresnel conductor reflectance unit.
`timescale 1ns / 1ps
package fcr_pkg;

    localparam int COS_W   = 17;
    localparam int INDEX_W = 20;
    localparam int REFL_W  = 17;

    typedef struct packed {
        logic [COS_W-1:0]   cos_incidence;
        logic [INDEX_W-1:0] index_real;
        logic [INDEX_W-1:0] index_extinction;
    } t_fcr_in;

    typedef struct packed {
        logic [REFL_W-1:0] reflect_perpendicular;
        logic [REFL_W-1:0] reflect_parallel;
    } t_fcr_out;

endpackage

### design/fresnel_conductor_reflectance_top.sv
// Fully pipelined Fresnel conductor reflectance unit: Rs and Rp from cos, n and k.
// Throughput: one item per cycle; busy is never raised and the result strobe cannot stall.
// The depth is set by the two bit-serial square root chains and the long-division chain.
// Reset (i_rst_n low at a clock edge, synchronous) clears every in-flight valid bit.
`timescale 1ns / 1ps
module fresnel_conductor_reflectance_top
    import fcr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_fcr_in  i_in,
    output logic     busy,
    output logic     o_valid,
    output t_fcr_out o_out
);

    // ---------------------------------------------------------------------------------------
    // Width plan. All values are unsigned, F fraction bits.
    //   CW  : cosine, c^2, s^2 (at most ONE)
    //   N2W : n^2, k^2
    //   DW  : |D| = |n^2 - k^2 - s^2|
    //   HW  : H = sqrt(D^2 + 4 n^2 k^2), root of a 2*HW bit operand
    //   AW  : A = sqrt(2 (H + D)), root of a 2*AW bit operand
    //   RW  : numerators and denominators of both ratios
    // ---------------------------------------------------------------------------------------
    localparam int F    = FRAC_BITS;
    localparam int CW   = F + 1;
    localparam int N2W  = 2 * INDEX_W - F;
    localparam int MW   = (N2W > CW) ? N2W : CW;
    localparam int DW   = MW + 1;
    localparam int HW   = DW + 1;
    localparam int HOW  = 2 * HW;
    localparam int AW   = (DW + F + 4) / 2;
    localparam int AOW  = 2 * AW;
    localparam int MX   = (HW > AW) ? HW : AW;
    localparam int RW   = MX + 2;
    localparam int XW   = RW + F + 1;
    localparam int EXW  = COS_W + F + 1;
    localparam int LAT  = 12 + HW + AW + F;

    localparam logic [CW-1:0]      ONE   = CW'(1) << F;
    localparam logic [EXW-1:0]     ONEX  = EXW'(1) << F;
    localparam logic [REFL_W-1:0]  ONE_OUT = ONEX[REFL_W-1:0];
    localparam logic [2*INDEX_W-1:0] HALF_N = (2*INDEX_W)'(1) << (F - 1);
    localparam logic [2*CW-1:0]    HALF_C = (2*CW)'(1) << (F - 1);
    localparam logic [AW+CW-1:0]   HALF_A = (AW+CW)'(1) << (F - 1);
    localparam logic [HW+CW-1:0]   HALF_H = (HW+CW)'(1) << (F - 1);

    // Sideband carried through the square root and divider chains
    typedef struct packed {
        logic [CW-1:0] c;
        logic [CW-1:0] c2;
        logic [CW-1:0] s2;
        logic          dneg;
        logic [DW-1:0] dmag;
        logic          cz;
    } t_hside;

    typedef struct packed {
        logic [CW-1:0] c;
        logic [CW-1:0] c2;
        logic [CW-1:0] s2;
        logic [HW-1:0] h;
        logic          cz;
    } t_aside;

    typedef struct packed {
        logic cz;   // cosine zero
        logic dzs;  // Rs denominator zero
        logic dzp;  // Rp factor denominator zero
    } t_dside;

    // Never stalls: a new item may be transferred every cycle.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid bits travel alongside the data
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end
    assign o_valid = r_vld[LAT-1];

    // ---------------------------------------------------------------------------------------
    // P1: clamp cosine, square c, n and k
    // ---------------------------------------------------------------------------------------
    logic [EXW-1:0]       n_cext;
    logic [CW-1:0]        n_cc;
    logic [2*CW-1:0]      n_cprod;
    logic [2*INDEX_W-1:0] n_nprod, n_kprod;

    always_comb begin
        n_cext  = EXW'(i_in.cos_incidence);
        n_cc    = (n_cext > ONEX) ? ONE : n_cext[CW-1:0];
        n_cprod = (2*CW)'(n_cc) * (2*CW)'(n_cc) + HALF_C;
        n_nprod = (2*INDEX_W)'(i_in.index_real) * (2*INDEX_W)'(i_in.index_real) + HALF_N;
        n_kprod = (2*INDEX_W)'(i_in.index_extinction) * (2*INDEX_W)'(i_in.index_extinction)
                  + HALF_N;
    end

    logic [CW-1:0]  r1_c, r1_c2;
    logic [N2W-1:0] r1_n2, r1_k2;
    logic           r1_cz;
    always_ff @(posedge i_clk) begin
        r1_c  <= n_cc;
        r1_c2 <= n_cprod[2*F:F];
        r1_n2 <= n_nprod[2*INDEX_W-1:F];
        r1_k2 <= n_kprod[2*INDEX_W-1:F];
        r1_cz <= (i_in.cos_incidence == '0);
    end

    // ---------------------------------------------------------------------------------------
    // P2: s^2 and D as sign and magnitude
    // ---------------------------------------------------------------------------------------
    logic [CW-1:0] n_s2;
    logic [DW-1:0] n_ks;
    always_comb begin
        n_s2 = ONE - r1_c2;
        n_ks = DW'(r1_k2) + DW'(n_s2);
    end

    t_hside         r2_s;
    logic [N2W-1:0] r2_n2, r2_k2;
    always_ff @(posedge i_clk) begin
        r2_s.c    <= r1_c;
        r2_s.c2   <= r1_c2;
        r2_s.s2   <= n_s2;
        r2_s.cz   <= r1_cz;
        r2_s.dneg <= (DW'(r1_n2) < n_ks);
        r2_s.dmag <= (DW'(r1_n2) >= n_ks) ? DW'(r1_n2) - n_ks : n_ks - DW'(r1_n2);
        r2_n2     <= r1_n2;
        r2_k2     <= r1_k2;
    end

    // ---------------------------------------------------------------------------------------
    // P3: D^2 and n^2 k^2
    // ---------------------------------------------------------------------------------------
    t_hside           r3_s;
    logic [2*DW-1:0]  r3_sq;
    logic [2*N2W-1:0] r3_nk;
    always_ff @(posedge i_clk) begin
        r3_s  <= r2_s;
        r3_sq <= (2*DW)'(r2_s.dmag) * (2*DW)'(r2_s.dmag);
        r3_nk <= (2*N2W)'(r2_n2) * (2*N2W)'(r2_k2);
    end

    // ---------------------------------------------------------------------------------------
    // H square root: one result bit per stage, index 0 is the loaded operand
    // ---------------------------------------------------------------------------------------
    logic [HOW-1:0] r_hop   [0:HW];
    logic [HW+1:0]  r_hrem  [0:HW];
    logic [HW-1:0]  r_hroot [0:HW];
    t_hside         r_hs    [0:HW];

    always_ff @(posedge i_clk) begin
        r_hop[0]   <= HOW'(r3_sq) + (HOW'(r3_nk) << 2);
        r_hrem[0]  <= '0;
        r_hroot[0] <= '0;
        r_hs[0]    <= r3_s;
    end

    for (genvar j = 0; j < HW; j++) begin : g_hsq
        logic [HW+3:0] n_tr, n_cd;
        always_comb begin
            n_tr = {r_hrem[j], r_hop[j][HOW-1-2*j -: 2]};
            n_cd = {2'b00, r_hroot[j], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_hop[j+1] <= r_hop[j];
            r_hs[j+1]  <= r_hs[j];
            if (n_tr >= n_cd) begin
                r_hrem[j+1]  <= (HW+2)'(n_tr - n_cd);
                r_hroot[j+1] <= {r_hroot[j][HW-2:0], 1'b1};
            end else begin
                r_hrem[j+1]  <= n_tr[HW+1:0];
                r_hroot[j+1] <= {r_hroot[j][HW-2:0], 1'b0};
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // A square root operand: 2 (H + D) shifted up by F; H - |D| clamps at zero when D is negative
    // ---------------------------------------------------------------------------------------
    logic [HW:0] n_hd;
    always_comb begin
        if (r_hs[HW].dneg) begin
            n_hd = (r_hroot[HW] >= HW'(r_hs[HW].dmag)) ?
                   (HW+1)'(r_hroot[HW]) - (HW+1)'(r_hs[HW].dmag) : '0;
        end else begin
            n_hd = (HW+1)'(r_hroot[HW]) + (HW+1)'(r_hs[HW].dmag);
        end
    end

    logic [AOW-1:0] r_aop   [0:AW];
    logic [AW+1:0]  r_arem  [0:AW];
    logic [AW-1:0]  r_aroot [0:AW];
    t_aside         r_as    [0:AW];

    always_ff @(posedge i_clk) begin
        r_aop[0]   <= AOW'(n_hd) << (F + 1);
        r_arem[0]  <= '0;
        r_aroot[0] <= '0;
        r_as[0].c  <= r_hs[HW].c;
        r_as[0].c2 <= r_hs[HW].c2;
        r_as[0].s2 <= r_hs[HW].s2;
        r_as[0].h  <= r_hroot[HW];
        r_as[0].cz <= r_hs[HW].cz;
    end

    for (genvar j = 0; j < AW; j++) begin : g_asq
        logic [AW+3:0] n_tr, n_cd;
        always_comb begin
            n_tr = {r_arem[j], r_aop[j][AOW-1-2*j -: 2]};
            n_cd = {2'b00, r_aroot[j], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_aop[j+1] <= r_aop[j];
            r_as[j+1]  <= r_as[j];
            if (n_tr >= n_cd) begin
                r_arem[j+1]  <= (AW+2)'(n_tr - n_cd);
                r_aroot[j+1] <= {r_aroot[j][AW-2:0], 1'b1};
            end else begin
                r_arem[j+1]  <= n_tr[AW+1:0];
                r_aroot[j+1] <= {r_aroot[j][AW-2:0], 1'b0};
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // P6: A c, A s^2, H c^2, s^2 s^2 (each rounded half up)
    // ---------------------------------------------------------------------------------------
    logic [AW+CW-1:0] n_acp, n_asp;
    logic [HW+CW-1:0] n_t1p;
    logic [2*CW-1:0]  n_t3p;
    always_comb begin
        n_acp = (AW+CW)'(r_aroot[AW]) * (AW+CW)'(r_as[AW].c) + HALF_A;
        n_asp = (AW+CW)'(r_aroot[AW]) * (AW+CW)'(r_as[AW].s2) + HALF_A;
        n_t1p = (HW+CW)'(r_as[AW].h) * (HW+CW)'(r_as[AW].c2) + HALF_H;
        n_t3p = (2*CW)'(r_as[AW].s2) * (2*CW)'(r_as[AW].s2) + HALF_C;
    end

    logic [CW-1:0] r6_c, r6_c2, r6_t3;
    logic [HW-1:0] r6_h, r6_t1;
    logic [AW-1:0] r6_ac, r6_as2;
    logic          r6_cz;
    always_ff @(posedge i_clk) begin
        r6_c   <= r_as[AW].c;
        r6_c2  <= r_as[AW].c2;
        r6_h   <= r_as[AW].h;
        r6_cz  <= r_as[AW].cz;
        r6_ac  <= n_acp[F+AW-1:F];
        r6_as2 <= n_asp[F+AW-1:F];
        r6_t1  <= n_t1p[F+HW-1:F];
        r6_t3  <= n_t3p[2*F:F];
    end

    // ---------------------------------------------------------------------------------------
    // P7: (A s^2) c, Rs numerator and denominator
    // ---------------------------------------------------------------------------------------
    logic [AW+CW-1:0] n_t2p;
    logic [RW-1:0]    n_ch;
    always_comb begin
        n_t2p = (AW+CW)'(r6_as2) * (AW+CW)'(r6_c) + HALF_A;
        n_ch  = RW'(r6_c2) + RW'(r6_h);
    end

    logic [RW-1:0] r7_ns, r7_ds;
    logic [HW-1:0] r7_t1;
    logic [CW-1:0] r7_t3;
    logic [AW-1:0] r7_t2;
    logic          r7_cz;
    always_ff @(posedge i_clk) begin
        r7_ds <= n_ch + RW'(r6_ac);
        r7_ns <= (n_ch >= RW'(r6_ac)) ? n_ch - RW'(r6_ac) : '0;
        r7_t1 <= r6_t1;
        r7_t3 <= r6_t3;
        r7_t2 <= n_t2p[F+AW-1:F];
        r7_cz <= r6_cz;
    end

    // ---------------------------------------------------------------------------------------
    // P8: Rp factor numerator and denominator
    // ---------------------------------------------------------------------------------------
    logic [RW-1:0] n_tt;
    assign n_tt = RW'(r7_t1) + RW'(r7_t3);

    logic [RW-1:0] r8_ns, r8_ds, r8_np, r8_dp;
    logic          r8_cz;
    always_ff @(posedge i_clk) begin
        r8_ns <= r7_ns;
        r8_ds <= r7_ds;
        r8_dp <= n_tt + RW'(r7_t2);
        r8_np <= (n_tt >= RW'(r7_t2)) ? n_tt - RW'(r7_t2) : '0;
        r8_cz <= r7_cz;
    end

    // ---------------------------------------------------------------------------------------
    // Dividers: q = (num * ONE + den/2) / den, one quotient bit per stage, both in parallel.
    // num <= den, so the quotient fits F+1 bits and the top of the dividend is below den.
    // ---------------------------------------------------------------------------------------
    logic [XW-1:0] n_xs, n_xp;
    always_comb begin
        n_xs = (XW'(r8_ns) << F) + XW'(r8_ds >> 1);
        n_xp = (XW'(r8_np) << F) + XW'(r8_dp >> 1);
    end

    logic [RW-1:0] r_srem [0:F+1];
    logic [RW-1:0] r_sden [0:F+1];
    logic [F:0]    r_slow [0:F+1];
    logic [F:0]    r_sq   [0:F+1];
    logic [RW-1:0] r_prem [0:F+1];
    logic [RW-1:0] r_pden [0:F+1];
    logic [F:0]    r_plow [0:F+1];
    logic [F:0]    r_pq   [0:F+1];
    t_dside        r_ds   [0:F+1];

    always_ff @(posedge i_clk) begin
        r_srem[0]  <= n_xs[XW-1:F+1];
        r_slow[0]  <= n_xs[F:0];
        r_sden[0]  <= r8_ds;
        r_sq[0]    <= '0;
        r_prem[0]  <= n_xp[XW-1:F+1];
        r_plow[0]  <= n_xp[F:0];
        r_pden[0]  <= r8_dp;
        r_pq[0]    <= '0;
        r_ds[0].cz  <= r8_cz;
        r_ds[0].dzs <= (r8_ds == '0);
        r_ds[0].dzp <= (r8_dp == '0);
    end

    for (genvar j = 0; j <= F; j++) begin : g_div
        logic [RW:0] n_trs, n_trp;
        always_comb begin
            n_trs = {r_srem[j], r_slow[j][F-j]};
            n_trp = {r_prem[j], r_plow[j][F-j]};
        end
        always_ff @(posedge i_clk) begin
            r_sden[j+1] <= r_sden[j];
            r_slow[j+1] <= r_slow[j];
            r_pden[j+1] <= r_pden[j];
            r_plow[j+1] <= r_plow[j];
            r_ds[j+1]   <= r_ds[j];
            if (n_trs >= {1'b0, r_sden[j]}) begin
                r_srem[j+1] <= RW'(n_trs - {1'b0, r_sden[j]});
                r_sq[j+1]   <= {r_sq[j][F-1:0], 1'b1};
            end else begin
                r_srem[j+1] <= n_trs[RW-1:0];
                r_sq[j+1]   <= {r_sq[j][F-1:0], 1'b0};
            end
            if (n_trp >= {1'b0, r_pden[j]}) begin
                r_prem[j+1] <= RW'(n_trp - {1'b0, r_pden[j]});
                r_pq[j+1]   <= {r_pq[j][F-1:0], 1'b1};
            end else begin
                r_prem[j+1] <= n_trp[RW-1:0];
                r_pq[j+1]   <= {r_pq[j][F-1:0], 1'b0};
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // P10: clamp both ratios to one
    // ---------------------------------------------------------------------------------------
    logic [CW-1:0] r10_rs, r10_fp;
    t_dside        r10_f;
    always_ff @(posedge i_clk) begin
        r10_rs <= (r_sq[F+1] > ONE) ? ONE : r_sq[F+1];
        r10_fp <= (r_pq[F+1] > ONE) ? ONE : r_pq[F+1];
        r10_f  <= r_ds[F+1];
    end

    // ---------------------------------------------------------------------------------------
    // P11: Rp = Rs * factor, special cases, truncate to the output width
    // ---------------------------------------------------------------------------------------
    logic [2*CW-1:0]      n_rpp;
    logic [CW-1:0]        n_rpv, n_rs, n_rp;
    logic [CW+REFL_W-1:0] n_rs_ext, n_rp_ext;
    always_comb begin
        n_rpp = (2*CW)'(r10_rs) * (2*CW)'(r10_fp) + HALF_C;
        n_rpv = (n_rpp[2*F:F] > ONE) ? ONE : n_rpp[2*F:F];
        if (r10_f.cz || r10_f.dzs) begin
            // grazing incidence or zero Rs denominator: total reflection
            n_rs = ONE;
            n_rp = ONE;
        end else if (r10_f.dzp) begin
            n_rs = r10_rs;
            n_rp = ONE;
        end else begin
            n_rs = r10_rs;
            n_rp = n_rpv;
        end
        n_rs_ext = (CW+REFL_W)'(n_rs);
        n_rp_ext = (CW+REFL_W)'(n_rp);
    end

    always_ff @(posedge i_clk) begin
        o_out.reflect_perpendicular <= n_rs_ext[REFL_W-1:0];
        o_out.reflect_parallel      <= n_rp_ext[REFL_W-1:0];
    end

    // ---------------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------------
    a_lat_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("transfer did not produce a result after LAT cycles");

    a_lat_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##LAT !o_valid)
        else $error("result strobe without a matching transfer");

    a_cos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.cos_incidence == '0) |-> ##LAT
        (o_out.reflect_perpendicular == ONE_OUT && o_out.reflect_parallel == ONE_OUT))
        else $error("zero cosine must give full reflectance");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((F > REFL_W - 1) ||
        (o_out.reflect_perpendicular <= ONE_OUT && o_out.reflect_parallel <= ONE_OUT)))
        else $error("reflectance above one");

endmodule
